>>> rtl/temperature_to_seven_segment_assert.svh
// Assertion macros shared by the temperature display pipeline.
`ifndef TEMPERATURE_TO_SEVEN_SEGMENT_ASSERT_SVH
`define TEMPERATURE_TO_SEVEN_SEGMENT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define T2SS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
else $error("t2ss assertion failed");
// Next-cycle implication, disabled during reset.
`define T2SS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
else $error("t2ss assertion failed");
`else
`define T2SS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define T2SS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/t2ss_pkg.sv
// Shared constants, types and the digit pattern table of the temperature display.
package t2ss_pkg;

   localparam int NUM_DIGITS_DEFAULT = 4;
   localparam int OUT_DIGITS         = 4;
   localparam int MAG_W              = 17;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_HIGH_LIMIT     = 2'd0;
   localparam logic [1:0] CSR_LOW_LIMIT      = 2'd1;
   localparam logic [1:0] CSR_DECIMAL_PLACES = 2'd2;
   localparam logic [1:0] CSR_FAHRENHEIT     = 2'd3;

   localparam logic signed [15:0] HIGH_LIMIT_RESET     = 16'sd1099;
   localparam logic signed [15:0] LOW_LIMIT_RESET      = 16'sd600;
   localparam logic [1:0]         DECIMAL_PLACES_RESET = 2'd1;
   localparam logic               FAHRENHEIT_RESET     = 1'b1;

   localparam logic signed [17:0] KELVIN_OFFSET  = 18'sd27315;
   localparam logic signed [14:0] SUPPLY_NOMINAL = 15'sd3000;
   localparam logic signed [21:0] FAHR_OFFSET    = 22'sd32000;

   // Reciprocals rounded up; each is exact over the operand range it meets.
   localparam logic [20:0] RECIP1000 = 21'd1073742;  // 2^30 / 1000
   localparam logic [20:0] RECIP10   = 21'd1677722;  // 2^24 / 10
   localparam logic [21:0] RECIP100  = 22'd2684355;  // 2^28 / 100

   localparam logic [7:0] SEG_A  = 8'h04;
   localparam logic [7:0] SEG_B  = 8'h01;
   localparam logic [7:0] SEG_C  = 8'h08;
   localparam logic [7:0] SEG_D  = 8'h80;
   localparam logic [7:0] SEG_E  = 8'h40;
   localparam logic [7:0] SEG_F  = 8'h10;
   localparam logic [7:0] SEG_G  = 8'h02;
   localparam logic [7:0] SEG_DP = 8'h20;
   localparam int         SEG_DP_BIT = 5;

   localparam logic [7:0] SEG_LETTER_H = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
   localparam logic [7:0] SEG_LETTER_I = SEG_B | SEG_C;
   localparam logic [7:0] SEG_LETTER_L = SEG_D | SEG_E | SEG_F;
   localparam logic [7:0] SEG_LETTER_O = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;

   typedef struct packed {
      logic             valid;
      logic             hi;
      logic             lo;
      logic             minus;
      logic [MAG_W-1:0] mag;
   } digit_bus_type;

   function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
         4'd1: pat = SEG_B | SEG_C;
         4'd2: pat = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
         4'd3: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
         4'd4: pat = SEG_B | SEG_C | SEG_F | SEG_G;
         4'd5: pat = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
         4'd6: pat = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         4'd7: pat = SEG_A | SEG_B | SEG_C;
         4'd8: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
         4'd9: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/t2ss_front.sv
// Arithmetic front end: compensation, scale, rounded division and limit compare.
`include "temperature_to_seven_segment_assert.svh"
module t2ss_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [14:0]              raw_temp,
   input  logic [12:0]              supply_mv,
   input  logic signed [15:0]       high_limit,
   input  logic signed [15:0]       low_limit,
   input  logic [1:0]               decimal_places,
   input  logic                     fahrenheit,
   output t2ss_pkg::digit_bus_type  out_bus
);

   localparam logic [1:0] DIV_1   = 2'd0;
   localparam logic [1:0] DIV_10  = 2'd1;
   localparam logic [1:0] DIV_100 = 2'd2;

   // Stage A: supply compensation numerator, split into sign and magnitude.
   logic signed [14:0] a_diff;
   logic signed [19:0] a_diff_w;
   logic signed [19:0] a_num;
   logic signed [19:0] a_abs;
   logic               a_valid_ff, a_valid_in;
   logic               a_neg_ff, a_neg_in;
   logic [18:0]        a_mag_ff, a_mag_in;
   logic [14:0]        a_raw_ff, a_raw_in;

   always_comb begin
      a_diff     = $signed({2'b00, supply_mv}) - t2ss_pkg::SUPPLY_NOMINAL;
      a_diff_w   = 20'(a_diff);
      a_num      = (a_diff_w <<< 6) - (a_diff_w <<< 2) + 20'sd500;
      a_abs      = a_num[19] ? -a_num : a_num;
      a_valid_in = in_valid;
      a_neg_in   = a_num[19];
      a_mag_in   = a_abs[18:0];
      a_raw_in   = raw_temp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_neg_ff <= a_neg_in;
      a_mag_ff <= a_mag_in;
      a_raw_ff <= a_raw_in;
   end

   // Stage B: truncating divide by 1000 on the magnitude.
   logic [39:0] b_prod;
   logic        b_valid_ff, b_valid_in;
   logic        b_neg_ff, b_neg_in;
   logic [8:0]  b_q_ff, b_q_in;
   logic [14:0] b_raw_ff, b_raw_in;

   always_comb begin
      b_prod     = 40'(a_mag_ff) * 40'(t2ss_pkg::RECIP1000);
      b_valid_in = a_valid_ff;
      b_neg_in   = a_neg_ff;
      b_q_in     = b_prod[38:30];
      b_raw_in   = a_raw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_neg_ff <= b_neg_in;
      b_q_ff   <= b_q_in;
      b_raw_ff <= b_raw_in;
   end

   // Stage C: centidegrees Celsius, optionally millidegrees Fahrenheit.
   logic signed [17:0] c_comp;
   logic signed [17:0] c_cel;
   logic signed [21:0] c_cel_w;
   logic signed [21:0] c_fahr;
   logic               c_valid_ff, c_valid_in;
   logic signed [21:0] c_val_ff, c_val_in;

   always_comb begin
      c_comp     = b_neg_ff ? -$signed({9'd0, b_q_ff}) : $signed({9'd0, b_q_ff});
      c_cel      = $signed({2'b00, b_raw_ff, 1'b0}) - t2ss_pkg::KELVIN_OFFSET - c_comp;
      c_cel_w    = 22'(c_cel);
      c_fahr     = (c_cel_w <<< 4) + (c_cel_w <<< 1) + t2ss_pkg::FAHR_OFFSET;
      c_val_in   = fahrenheit ? c_fahr : c_cel_w;
      c_valid_in = b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_val_ff <= c_val_in;
   end

   // Stage D: divide the magnitude with round half away from zero.
   logic [1:0]         d_div;
   logic signed [21:0] d_abs_s;
   logic [19:0]        d_half;
   logic [19:0]        d_num;
   logic [21:0]        d_recip;
   logic [41:0]        d_prod;
   logic               d_valid_ff, d_valid_in;
   logic               d_neg_ff, d_neg_in;
   logic [t2ss_pkg::MAG_W-1:0] d_mag_ff, d_mag_in;

   always_comb begin
      if (fahrenheit) begin
         d_div = (decimal_places == 2'd1) ? DIV_100 : DIV_10;
      end else begin
         d_div = (decimal_places == 2'd1) ? DIV_10 : DIV_1;
      end
      case (d_div)
         DIV_10:  d_half = 20'd5;
         DIV_100: d_half = 20'd50;
         default: d_half = 20'd0;
      endcase
      d_recip = (d_div == DIV_100) ? t2ss_pkg::RECIP100 : 22'(t2ss_pkg::RECIP10);
      d_abs_s = c_val_ff[21] ? -c_val_ff : c_val_ff;
      d_num   = d_abs_s[19:0] + d_half;
      d_prod  = 42'(d_num) * 42'(d_recip);
      case (d_div)
         DIV_10:  d_mag_in = d_prod[24 +: t2ss_pkg::MAG_W];
         DIV_100: d_mag_in = t2ss_pkg::MAG_W'(d_prod[41:28]);
         default: d_mag_in = d_num[t2ss_pkg::MAG_W-1:0];
      endcase
      d_neg_in   = c_val_ff[21];
      d_valid_in = c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_neg_ff <= d_neg_in;
      d_mag_ff <= d_mag_in;
   end

   // Stage E: signed compare against the limits at full width.
   logic signed [17:0]      e_num;
   t2ss_pkg::digit_bus_type e_bus_ff, e_bus_in;

   always_comb begin
      e_num = d_neg_ff ? -$signed({1'b0, d_mag_ff}) : $signed({1'b0, d_mag_ff});
      e_bus_in.valid = d_valid_ff;
      e_bus_in.hi    = e_num > 18'(high_limit);
      e_bus_in.lo    = e_num < 18'(low_limit);
      e_bus_in.minus = d_neg_ff && (d_mag_ff != '0);
      e_bus_in.mag   = d_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_bus_ff <= '0;
      end else begin
         e_bus_ff <= e_bus_in;
      end
   end

   assign out_bus = e_bus_ff;

   // An in-range value lies within the 16-bit limits, so its magnitude is small.
   `T2SS_ASSERT_IMPL(a_in_range_mag, clock, reset, out_bus.valid && !out_bus.hi && !out_bus.lo, out_bus.mag <= 17'd32768)
   `T2SS_ASSERT_IMPL(a_minus_nonzero, clock, reset, out_bus.valid && out_bus.minus, out_bus.mag != '0)

endmodule

>>> rtl/t2ss_digit.sv
// One digit stage: peels off a decimal digit and applies blanking, sign and point.
`include "temperature_to_seven_segment_assert.svh"
module t2ss_digit #(
   parameter int NUM_DIGITS = t2ss_pkg::NUM_DIGITS_DEFAULT,
   parameter int POSITION   = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               decimal_places,
   input  t2ss_pkg::digit_bus_type  in_bus,
   input  logic [NUM_DIGITS*8-1:0]  in_segs,
   output t2ss_pkg::digit_bus_type  out_bus,
   output logic [NUM_DIGITS*8-1:0]  out_segs
);

   localparam logic [3:0] POS = 4'(POSITION);

   logic [37:0]                prod;
   logic [t2ss_pkg::MAG_W-1:0] quot;
   logic [t2ss_pkg::MAG_W-1:0] rem;
   logic [3:0]                 fixed_digits;
   logic                       blank_zone;
   logic [7:0]                 seg;
   t2ss_pkg::digit_bus_type    bus_ff, bus_in;
   logic [NUM_DIGITS*8-1:0]    segs_ff, segs_in;

   always_comb begin
      prod         = 38'(in_bus.mag) * 38'(t2ss_pkg::RECIP10);
      quot         = t2ss_pkg::MAG_W'(prod[37:24]);
      rem          = in_bus.mag - (quot << 3) - (quot << 1);
      fixed_digits = {2'b00, decimal_places} + 4'd1;
      blank_zone   = (POS >= fixed_digits) && (in_bus.mag == '0);
      bus_in       = in_bus;
      bus_in.mag   = quot;
      seg          = t2ss_pkg::digit_pattern(rem[3:0]);
      // The first blank position past the forced digits carries the sign.
      if (blank_zone) begin
         if (in_bus.minus) begin
            seg          = t2ss_pkg::SEG_G;
            bus_in.minus = 1'b0;
         end else begin
            seg = 8'h00;
         end
      end
      if (POS == {2'b00, decimal_places}) begin
         seg = seg | t2ss_pkg::SEG_DP;
      end
      segs_in = in_segs;
      segs_in[POSITION*8 +: 8] = seg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff <= '0;
      end else begin
         bus_ff <= bus_in;
      end
   end

   always_ff @(posedge clock) begin
      segs_ff <= segs_in;
   end

   assign out_bus  = bus_ff;
   assign out_segs = segs_ff;

   `T2SS_ASSERT_NEXT(a_point_lit, clock, reset, in_bus.valid && (POS == {2'b00, decimal_places}), out_segs[POSITION*8 + t2ss_pkg::SEG_DP_BIT])

endmodule

>>> rtl/t2ss_format.sv
// Output stage: selects digits or HI/LO letters and registers the four segment bytes.
`include "temperature_to_seven_segment_assert.svh"
module t2ss_format #(
   parameter int NUM_DIGITS = t2ss_pkg::NUM_DIGITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  t2ss_pkg::digit_bus_type  in_bus,
   input  logic [NUM_DIGITS*8-1:0]  in_segs,
   output logic                     out_valid,
   output logic [t2ss_pkg::OUT_DIGITS-1:0][7:0] out_segs
);

   localparam int PAD_DIGITS = (NUM_DIGITS > t2ss_pkg::OUT_DIGITS) ?
                               NUM_DIGITS : t2ss_pkg::OUT_DIGITS;

   logic [PAD_DIGITS*8-1:0]                padded;
   logic [t2ss_pkg::OUT_DIGITS-1:0][7:0]   letters;
   logic                                   valid_ff, valid_in;
   logic [t2ss_pkg::OUT_DIGITS-1:0][7:0]   segs_ff, segs_in;

   assign padded = (PAD_DIGITS*8)'(in_segs);

   // Letters fill from the top digit down: H, I when high, L, O when low, and H, I, L, O when both.
   for (genvar p = 0; p < t2ss_pkg::OUT_DIGITS; p++) begin : g_letter
      localparam int SLOT = NUM_DIGITS - 1 - p;
      assign letters[p] =
         (SLOT == 0) ? (in_bus.hi ? t2ss_pkg::SEG_LETTER_H :
                        (in_bus.lo ? t2ss_pkg::SEG_LETTER_L : 8'h00)) :
         (SLOT == 1) ? (in_bus.hi ? t2ss_pkg::SEG_LETTER_I :
                        (in_bus.lo ? t2ss_pkg::SEG_LETTER_O : 8'h00)) :
         (SLOT == 2) ? ((in_bus.hi && in_bus.lo) ? t2ss_pkg::SEG_LETTER_L : 8'h00) :
         (SLOT == 3) ? ((in_bus.hi && in_bus.lo) ? t2ss_pkg::SEG_LETTER_O : 8'h00) :
                       8'h00;
      assign segs_in[p] = (in_bus.hi || in_bus.lo) ? letters[p] : padded[p*8 +: 8];
   end

   assign valid_in = in_bus.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      segs_ff <= segs_in;
   end

   assign out_valid = valid_ff;
   assign out_segs  = segs_ff;

   `T2SS_ASSERT_NEXT(a_letters_no_point, clock, reset, in_bus.valid && (in_bus.hi || in_bus.lo), !segs_ff[0][t2ss_pkg::SEG_DP_BIT] && !segs_ff[1][t2ss_pkg::SEG_DP_BIT] && !segs_ff[2][t2ss_pkg::SEG_DP_BIT] && !segs_ff[3][t2ss_pkg::SEG_DP_BIT])

endmodule

>>> rtl/temperature_to_seven_segment.sv
// Top level: configuration registers and the temperature display pipeline.
//
//   Channel   Ports                                   Handshake
//   request   req_raw_temp, req_supply_mv             start high, busy low
//   response  rsp_seg_digit0..rsp_seg_digit3          rsp_valid strobe, one cycle
//   config    csr_index, csr_wdata                    csr_we, taken at once
//
// One item enters every cycle; busy is never raised.
// The pipeline has five arithmetic stages (supply numerator,
// compensation divide, scaling, rounded divide, limit compare), one stage per
// digit, and the output register. Reset clears the valid bits and loads the
// register defaults; the receiver cannot stall, so the pipeline never holds.
module temperature_to_seven_segment #(
   parameter int NUM_DIGITS = t2ss_pkg::NUM_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [14:0] req_raw_temp,
   input  logic [12:0] req_supply_mv,
   output logic        rsp_valid,
   output logic [7:0]  rsp_seg_digit0,
   output logic [7:0]  rsp_seg_digit1,
   output logic [7:0]  rsp_seg_digit2,
   output logic [7:0]  rsp_seg_digit3,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic signed [15:0] high_limit_ff, high_limit_in;
   logic signed [15:0] low_limit_ff, low_limit_in;
   logic [1:0]         decimal_places_ff, decimal_places_in;
   logic               fahrenheit_ff, fahrenheit_in;

   always_comb begin
      high_limit_in     = high_limit_ff;
      low_limit_in      = low_limit_ff;
      decimal_places_in = decimal_places_ff;
      fahrenheit_in     = fahrenheit_ff;
      if (csr_we) begin
         case (csr_index)
            t2ss_pkg::CSR_HIGH_LIMIT:     high_limit_in     = $signed(csr_wdata);
            t2ss_pkg::CSR_LOW_LIMIT:      low_limit_in      = $signed(csr_wdata);
            t2ss_pkg::CSR_DECIMAL_PLACES: decimal_places_in = csr_wdata[1:0];
            t2ss_pkg::CSR_FAHRENHEIT:     fahrenheit_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_limit_ff     <= t2ss_pkg::HIGH_LIMIT_RESET;
         low_limit_ff      <= t2ss_pkg::LOW_LIMIT_RESET;
         decimal_places_ff <= t2ss_pkg::DECIMAL_PLACES_RESET;
         fahrenheit_ff     <= t2ss_pkg::FAHRENHEIT_RESET;
      end else begin
         high_limit_ff     <= high_limit_in;
         low_limit_ff      <= low_limit_in;
         decimal_places_ff <= decimal_places_in;
         fahrenheit_ff     <= fahrenheit_in;
      end
   end

   assign busy = 1'b0;

   t2ss_pkg::digit_bus_type chain_bus  [NUM_DIGITS+1];
   logic [NUM_DIGITS*8-1:0] chain_segs [NUM_DIGITS+1];

   t2ss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start && !busy),
      .raw_temp       (req_raw_temp),
      .supply_mv      (req_supply_mv),
      .high_limit     (high_limit_ff),
      .low_limit      (low_limit_ff),
      .decimal_places (decimal_places_ff),
      .fahrenheit     (fahrenheit_ff),
      .out_bus        (chain_bus[0])
   );

   assign chain_segs[0] = '0;

   for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_digit
      t2ss_digit #(
         .NUM_DIGITS (NUM_DIGITS),
         .POSITION   (p)
      ) u_digit (
         .clock          (clock),
         .reset          (reset),
         .decimal_places (decimal_places_ff),
         .in_bus         (chain_bus[p]),
         .in_segs        (chain_segs[p]),
         .out_bus        (chain_bus[p+1]),
         .out_segs       (chain_segs[p+1])
      );
   end

   logic [t2ss_pkg::OUT_DIGITS-1:0][7:0] out_segs;

   t2ss_format #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_format (
      .clock     (clock),
      .reset     (reset),
      .in_bus    (chain_bus[NUM_DIGITS]),
      .in_segs   (chain_segs[NUM_DIGITS]),
      .out_valid (rsp_valid),
      .out_segs  (out_segs)
   );

   assign rsp_seg_digit0 = out_segs[0];
   assign rsp_seg_digit1 = out_segs[1];
   assign rsp_seg_digit2 = out_segs[2];
   assign rsp_seg_digit3 = out_segs[3];

endmodule
